// ===== design/hash_integer_token_parser_defines.svh =====
// ----------------------------------------------------------------------------
// hash_integer_token_parser_defines
// Assertion macros for the hash integer token parser.
// ----------------------------------------------------------------------------
// Define ASSERT_OFF to compile the checks out.
`ifndef HASH_INTEGER_TOKEN_PARSER_DEFINES_SVH
`define HASH_INTEGER_TOKEN_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
// Property holds at every clock edge outside reset
`define HITP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next
`define HITP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HITP_ASSERT(lbl, clk, rst_n, prop, msg)
`define HITP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/hitp_pkg.sv =====
// ----------------------------------------------------------------------------
// hitp_pkg
// Shared types and codes of the hash integer token parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hitp_pkg;

    localparam int unsigned OUT_BITS = 64;
    localparam int unsigned Q_DEPTH  = 2;
    localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W  = $clog2(Q_DEPTH + 1);

    // text bytes of interest
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SUF_H = 8'h68;
    localparam logic [7:0] CH_SUF_O = 8'h6F;

    // base codes
    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_BIN = 2'd1;
    localparam logic [1:0] BASE_OCT = 2'd2;
    localparam logic [1:0] BASE_HEX = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_DIGIT = 2'd1;
    localparam logic [1:0] ST_BAD_DIGIT = 2'd2;

    // largest digit allowed per base
    localparam logic [3:0] LIM_BIN = 4'd1;
    localparam logic [3:0] LIM_OCT = 4'd7;
    localparam logic [3:0] LIM_DEC = 4'd9;
    localparam logic [3:0] LIM_HEX = 4'd15;

    // parser phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_HASH = 3'b010,
        PH_ACC  = 3'b100
    } t_phase;

    // classified byte, as queued between front and back
    typedef struct packed {
        logic       is_hash;
        logic       is_space;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_suf_h;
        logic       is_suf_o;
    } t_cls;

    // queue status toward the rest of the block
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // one result item
    typedef struct packed {
        logic [OUT_BITS-1:0] value;
        logic [1:0]          status;
        logic                overflowed;
        logic [1:0]          base_code;
        logic                end_consumed;
    } t_res;

endpackage

`default_nettype wire

// ===== design/hash_integer_token_parser_ifs.sv =====
// ----------------------------------------------------------------------------
// hash_integer_token_parser channel interfaces
// Valid/ready channels for text bytes in and parse results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hitp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface hitp_out_if;
    logic                           valid;
    logic                           ready;
    logic [hitp_pkg::OUT_BITS-1:0]  value;
    logic [1:0]                     status;
    logic                           overflowed;
    logic [1:0]                     base_code;
    logic                           end_consumed;

    modport source (output valid, output value, output status, output overflowed,
                    output base_code, output end_consumed, input ready);
    modport sink   (input valid, input value, input status, input overflowed,
                    input base_code, input end_consumed, output ready);
endinterface

`default_nettype wire

// ===== design/hitp_front.sv =====
// ----------------------------------------------------------------------------
// hitp_front
// Takes text bytes and classifies them for the parse engine.
// ----------------------------------------------------------------------------
`default_nettype none

module hitp_front (
    hitp_in_if.sink          i_in,
    input  hitp_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output hitp_pkg::t_cls   o_cls
);

    // byte -> class and hex weight
    function automatic hitp_pkg::t_cls classify(input logic [7:0] b);
        hitp_pkg::t_cls c;
        c          = '0;
        c.is_hash  = (b == hitp_pkg::CH_HASH);
        c.is_space = (b == hitp_pkg::CH_SPACE);
        c.is_suf_h = (b == hitp_pkg::CH_SUF_H);
        c.is_suf_o = (b == hitp_pkg::CH_SUF_O);
        if (b >= 8'h30 && b <= 8'h39) begin
            c.is_digit = 1'b1;
            c.digit    = 4'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            c.is_digit = 1'b1;
            c.digit    = 4'(b - 8'h37);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            c.is_digit = 1'b1;
            c.digit    = 4'(b - 8'h57);
        end
        return c;
    endfunction

    // transfer whenever the queue has room
    assign i_in.ready = !i_q_stat.full;
    assign o_push     = i_in.valid && !i_q_stat.full;
    assign o_cls      = classify(i_in.in_byte);

endmodule

`default_nettype wire

// ===== design/hitp_queue.sv =====
// ----------------------------------------------------------------------------
// hitp_queue
// Two-entry queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module hitp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hitp_pkg::t_cls    i_data,
    input  logic              i_pop,
    output hitp_pkg::t_cls    o_data,
    output hitp_pkg::t_q_stat o_stat
);

    hitp_pkg::t_cls                   r_mem [hitp_pkg::Q_DEPTH];
    logic [hitp_pkg::Q_PTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [hitp_pkg::Q_PTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [hitp_pkg::Q_CNT_W-1:0]     r_cnt, n_cnt;
    logic                             w_push, w_pop;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == hitp_pkg::Q_CNT_W'(hitp_pkg::Q_DEPTH));
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == hitp_pkg::Q_PTR_W'(hitp_pkg::Q_DEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == hitp_pkg::Q_PTR_W'(hitp_pkg::Q_DEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/hitp_back.sv =====
// ----------------------------------------------------------------------------
// hitp_back
// Token state machine, four-base accumulators and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hitp_back #(
    parameter int unsigned VALUE_BITS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_wr_data,
    input  hitp_pkg::t_cls    i_cls,
    input  hitp_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    hitp_out_if.source        o_out
);

    localparam int unsigned W = VALUE_BITS + 5;

    hitp_pkg::t_phase        r_phase, n_phase;
    logic [VALUE_BITS-1:0]   r_acc_bin, n_acc_bin;
    logic [VALUE_BITS-1:0]   r_acc_oct, n_acc_oct;
    logic [VALUE_BITS-1:0]   r_acc_dec, n_acc_dec;
    logic [VALUE_BITS-1:0]   r_acc_hex, n_acc_hex;
    logic [3:0]              r_ovf, n_ovf;
    logic                    r_seen, n_seen;
    logic [3:0]              r_maxd, n_maxd;
    logic [1:0]              r_base;
    logic                    r_out_valid, n_out_valid;
    hitp_pkg::t_res          r_res, n_res;

    logic [W-1:0]            w_ext, w_dig;
    logic [W-1:0]            w_bin, w_oct, w_dec, w_hex;
    logic                    w_res;
    logic [1:0]              w_code;
    logic [3:0]              w_lim;
    logic                    w_flag;
    logic [VALUE_BITS-1:0]   w_acc;

    assign o_pop = !i_q_stat.empty && (!r_out_valid || o_out.ready);

    // next accumulator values in every base
    always_comb begin
        w_dig = W'(i_cls.digit);
        w_ext = W'(r_acc_bin);
        w_bin = (w_ext << 1) + w_dig;
        w_ext = W'(r_acc_oct);
        w_oct = (w_ext << 3) + w_dig;
        w_ext = W'(r_acc_dec);
        w_dec = (w_ext << 3) + (w_ext << 1) + w_dig;
        w_ext = W'(r_acc_hex);
        w_hex = (w_ext << 4) + w_dig;
    end

    // base chosen at token end
    always_comb begin
        if (i_cls.is_suf_h) begin
            w_code = hitp_pkg::BASE_HEX;
        end else if (i_cls.is_suf_o) begin
            w_code = hitp_pkg::BASE_OCT;
        end else begin
            w_code = r_base;
        end
        unique case (w_code)
            hitp_pkg::BASE_BIN: begin
                w_lim = hitp_pkg::LIM_BIN; w_acc = r_acc_bin; w_flag = r_ovf[0];
            end
            hitp_pkg::BASE_OCT: begin
                w_lim = hitp_pkg::LIM_OCT; w_acc = r_acc_oct; w_flag = r_ovf[1];
            end
            hitp_pkg::BASE_HEX: begin
                w_lim = hitp_pkg::LIM_HEX; w_acc = r_acc_hex; w_flag = r_ovf[3];
            end
            default: begin
                w_lim = hitp_pkg::LIM_DEC; w_acc = r_acc_dec; w_flag = r_ovf[2];
            end
        endcase
    end

    // token state machine
    always_comb begin
        n_phase   = r_phase;
        n_acc_bin = r_acc_bin;
        n_acc_oct = r_acc_oct;
        n_acc_dec = r_acc_dec;
        n_acc_hex = r_acc_hex;
        n_ovf     = r_ovf;
        n_seen    = r_seen;
        n_maxd    = r_maxd;
        w_res     = 1'b0;
        n_res     = r_res;

        if (o_pop) begin
            unique case (r_phase)
                hitp_pkg::PH_HASH, hitp_pkg::PH_ACC: begin
                    n_phase = hitp_pkg::PH_ACC;
                    if (r_phase == hitp_pkg::PH_HASH && i_cls.is_space) begin
                        n_phase = hitp_pkg::PH_ACC;
                    end else if (i_cls.is_digit) begin
                        // saturate on carry out of the value width
                        if (|w_bin[W-1:VALUE_BITS]) begin
                            n_acc_bin = '1; n_ovf[0] = 1'b1;
                        end else begin
                            n_acc_bin = w_bin[VALUE_BITS-1:0];
                        end
                        if (|w_oct[W-1:VALUE_BITS]) begin
                            n_acc_oct = '1; n_ovf[1] = 1'b1;
                        end else begin
                            n_acc_oct = w_oct[VALUE_BITS-1:0];
                        end
                        if (|w_dec[W-1:VALUE_BITS]) begin
                            n_acc_dec = '1; n_ovf[2] = 1'b1;
                        end else begin
                            n_acc_dec = w_dec[VALUE_BITS-1:0];
                        end
                        if (|w_hex[W-1:VALUE_BITS]) begin
                            n_acc_hex = '1; n_ovf[3] = 1'b1;
                        end else begin
                            n_acc_hex = w_hex[VALUE_BITS-1:0];
                        end
                        n_seen = 1'b1;
                        if (i_cls.digit > r_maxd) begin
                            n_maxd = i_cls.digit;
                        end
                    end else begin
                        // token ends on this byte
                        w_res              = 1'b1;
                        n_res.base_code    = w_code;
                        n_res.end_consumed = i_cls.is_suf_h || i_cls.is_suf_o;
                        n_res.value        = '0;
                        n_res.overflowed   = 1'b0;
                        if (!r_seen) begin
                            n_res.status = hitp_pkg::ST_NO_DIGIT;
                        end else if (r_maxd > w_lim) begin
                            n_res.status = hitp_pkg::ST_BAD_DIGIT;
                        end else begin
                            n_res.status     = hitp_pkg::ST_OK;
                            n_res.value      = hitp_pkg::OUT_BITS'(w_acc);
                            n_res.overflowed = w_flag;
                        end
                        n_phase = hitp_pkg::PH_IDLE;
                        if (i_cls.is_hash) begin
                            n_phase   = hitp_pkg::PH_HASH;
                            n_acc_bin = '0;
                            n_acc_oct = '0;
                            n_acc_dec = '0;
                            n_acc_hex = '0;
                            n_ovf     = '0;
                            n_seen    = 1'b0;
                            n_maxd    = '0;
                        end
                    end
                end
                default: begin
                    n_phase = hitp_pkg::PH_IDLE;
                    if (i_cls.is_hash) begin
                        n_phase   = hitp_pkg::PH_HASH;
                        n_acc_bin = '0;
                        n_acc_oct = '0;
                        n_acc_dec = '0;
                        n_acc_hex = '0;
                        n_ovf     = '0;
                        n_seen    = 1'b0;
                        n_maxd    = '0;
                    end
                end
            endcase
        end
    end

    // output register valid
    always_comb begin
        if (w_res) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= hitp_pkg::PH_IDLE;
            r_out_valid <= 1'b0;
            r_base      <= hitp_pkg::BASE_DEC;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_base <= i_cfg_wr_data;
            end
        end
    end

    // token data and result payload
    always_ff @(posedge i_clk) begin
        r_acc_bin <= n_acc_bin;
        r_acc_oct <= n_acc_oct;
        r_acc_dec <= n_acc_dec;
        r_acc_hex <= n_acc_hex;
        r_ovf     <= n_ovf;
        r_seen    <= n_seen;
        r_maxd    <= n_maxd;
        r_res     <= n_res;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.value        = r_res.value;
    assign o_out.status       = r_res.status;
    assign o_out.overflowed   = r_res.overflowed;
    assign o_out.base_code    = r_res.base_code;
    assign o_out.end_consumed = r_res.end_consumed;

endmodule

`default_nettype wire

// ===== design/hash_integer_token_parser.sv =====
// ----------------------------------------------------------------------------
// hash_integer_token_parser
// Parses '#'-prefixed integer literals from a byte stream, one byte per cycle.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle with no gaps of its own: bytes are
// classified on entry, pass through a two-entry queue and are consumed by the
// parse engine at one per cycle, which keeps binary, octal, decimal and hex
// accumulators in step. A token's result is loaded into the output register on
// the edge at which its ending byte leaves the queue and can be taken from the
// next cycle on. While a result waits in the output register and the output is
// not ready, the engine takes no bytes; the queue then fills and input ready
// drops once it holds two bytes. Sustained rate is one byte per cycle while the
// output is ready, set by the accumulator update; the default base register
// should be written only while the stream is idle. VALUE_BITS sets the
// accumulator width; results are zero-extended to 64 bits.
`default_nettype none

`include "hash_integer_token_parser_defines.svh"

module hash_integer_token_parser #(
    parameter int unsigned VALUE_BITS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_wr_data,
    hitp_in_if.sink    i_in,
    hitp_out_if.source o_out
);

    hitp_pkg::t_cls    w_push_cls;
    hitp_pkg::t_cls    w_pop_cls;
    hitp_pkg::t_q_stat w_q_stat;
    logic              w_push;
    logic              w_pop;

    // byte classification
    hitp_front u_front (
        .i_in     (i_in),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_cls    (w_push_cls)
    );

    // decoupling queue
    hitp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cls),
        .i_pop   (w_pop),
        .o_data  (w_pop_cls),
        .o_stat  (w_q_stat)
    );

    // parse engine
    hitp_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cls         (w_pop_cls),
        .i_q_stat      (w_q_stat),
        .o_pop         (w_pop),
        .o_out         (o_out)
    );

    // checks
    `HITP_ASSERT(a_q_stat_sane, i_clk, i_rst_n,
        !(w_q_stat.full && w_q_stat.empty), "queue full and empty")
    `HITP_ASSERT_NEXT(a_q_stays_empty, i_clk, i_rst_n,
        w_q_stat.empty && !w_push, w_q_stat.empty, "queue filled without a transfer")
    `HITP_ASSERT(a_err_zero, i_clk, i_rst_n,
        !(o_out.valid && o_out.status != hitp_pkg::ST_OK) ||
        (o_out.value == '0 && !o_out.overflowed), "error result carries a value")
    `HITP_ASSERT(a_suffix_base, i_clk, i_rst_n,
        !(o_out.valid && o_out.end_consumed) || o_out.base_code == hitp_pkg::BASE_HEX ||
        o_out.base_code == hitp_pkg::BASE_OCT, "consumed suffix with wrong base")

endmodule

`default_nettype wire
